// File: hdl/skaf_pkg.sv
// Shared constants, register indexes and sequencer states for the scalar Kalman angle fusion unit.
// Depends on nothing.
package skaf_pkg;

  localparam int DEF_NUM_CHANNELS = 5;
  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 16;
  localparam int ANGLE_W = 32;
  localparam int VAR_W = 32;
  localparam int CH_IN_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [VAR_W-1:0] VAR_RESET = VAR_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [VAR_W-1:0] PN_RESET = VAR_W'((64'd1 << FRAC_BITS) / 100);
  localparam logic [VAR_W-1:0] MN_RESET = VAR_W'(64'd1 << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PRIOR = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_SQRT  = 8'b0000_1000,
    ST_MUL1  = 8'b0001_0000,
    ST_MUL2  = 8'b0010_0000,
    ST_VAR   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

endpackage

// File: hdl/scalar_kalman_angle_fusion_unit.sv
// Scalar Kalman angle fusion unit: top level with per-channel variance registers,
// a bit-serial divider, a bit-serial square root and one shared multiplier. Depends on skaf_pkg.
// A valid channel runs prior, divide steps, square root steps, multiply passes MUL1 and MUL2,
// variance update and output load; a bad channel goes straight to output load.
// A new request is taken only after the previous result has been loaded into the output.
// Synchronous reset (rst_n low): process noise ~0.01, measure noise 1.0, all variances 0.5.
module scalar_kalman_angle_fusion_unit
  import skaf_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CH_IN_W-1:0]        in_channel,
  input  logic signed [ANGLE_W-1:0] in_predicted_angle,
  input  logic signed [ANGLE_W-1:0] in_measured_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ANGLE_W-1:0] out_filtered_angle,
  output logic                      out_bad_channel,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [VAR_W-1:0]          cfg_wdata
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_W = 7;
  localparam int PROD_W = 52;
  localparam int ACC_W = 54;
  localparam logic [GAIN_BITS:0] GAIN_ONE = (GAIN_BITS+1)'(1) << GAIN_BITS;

  state_t state_r, state_nxt;

  logic [VAR_W-1:0] pn_r, mn_r;
  logic [VAR_W-1:0] var_r [NUM_CHANNELS];

  logic [IDX_W-1:0]          ch_r;
  logic signed [ANGLE_W-1:0] pred_r, meas_r;
  logic                      bad_r;

  logic [VAR_W-1:0]   p_r;
  logic [VAR_W:0]     den_r;
  logic [VAR_W+1:0]   rem_r;
  logic [VAR_W:0]     quo_r;
  logic [5:0]         cnt_r;
  logic [VAR_W:0]     v_r;
  logic [VAR_W+1:0]   res_r;
  logic [VAR_W:0]     bit_r;
  logic [GAIN_BITS:0] gain_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ANGLE_W-1:0] angle_r;

  logic                      out_valid_r;
  logic signed [ANGLE_W-1:0] out_angle_r;
  logic                      out_bad_r;

  logic                      in_take;
  logic                      out_free;
  logic [VAR_W:0]            prior_sum;
  logic [VAR_W-1:0]          prior_sat;
  logic [VAR_W+1:0]          div_trial;
  logic                      div_ge;
  logic [VAR_W+1:0]          div_rem_nxt;
  logic [VAR_W:0]            quo_nxt;
  logic [VAR_W+1:0]          sq_sum;
  logic                      sq_ge;
  logic [VAR_W+1:0]          sq_res_nxt;
  logic signed [ANGLE_W:0]   diff;
  logic signed [VAR_W+1:0]   mul_a;
  logic signed [GAIN_BITS+1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_sh;
  logic [PROD_W-1:0]         nv_sum;
  logic [PROD_W-1:0]         nv_sh;
  logic [VAR_W-1:0]          nv_sat;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_filtered_angle = out_angle_r;
  assign out_bad_channel = out_bad_r;

  assign prior_sum = {1'b0, var_r[ch_r]} + {1'b0, pn_r};
  assign prior_sat = prior_sum[VAR_W] ? '1 : prior_sum[VAR_W-1:0];

  assign div_trial = (cnt_r == '0) ? {2'b00, p_r} : {rem_r[VAR_W:0], 1'b0};
  assign div_ge = div_trial >= {1'b0, den_r};
  assign div_rem_nxt = div_ge ? (div_trial - {1'b0, den_r}) : div_trial;
  assign quo_nxt = {quo_r[VAR_W-1:0], div_ge};

  assign sq_sum = res_r + {1'b0, bit_r};
  assign sq_ge = {1'b0, v_r} >= sq_sum;
  assign sq_res_nxt = sq_ge ? ((res_r >> 1) + {1'b0, bit_r}) : (res_r >> 1);

  assign diff = {meas_r[ANGLE_W-1], meas_r} - {pred_r[ANGLE_W-1], pred_r};

  always_comb begin
    if (state_r == ST_MUL1) begin
      mul_a = {diff[ANGLE_W], diff};
      mul_b = {1'b0, gain_r};
    end else begin
      mul_a = {2'b00, p_r};
      mul_b = {1'b0, GAIN_ONE - gain_r};
    end
  end

  assign mul_p = mul_a * mul_b;

  assign acc = ({{(ACC_W-ANGLE_W){pred_r[ANGLE_W-1]}}, pred_r} <<< GAIN_BITS)
             + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r}
             + ACC_W'(1 << (GAIN_BITS - 1));
  assign acc_sh = acc >>> GAIN_BITS;

  assign nv_sum = prod_r + PROD_W'(1 << (GAIN_BITS - 1));
  assign nv_sh = nv_sum >> GAIN_BITS;
  assign nv_sat = (nv_sh[PROD_W-1:VAR_W] != '0) ? '1 : nv_sh[VAR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if ({{(CMP_W-CH_IN_W){1'b0}}, in_channel} >= CMP_W'(NUM_CHANNELS)) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_PRIOR;
          end
        end
      end
      ST_PRIOR: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == 6'(VAR_W)) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_r == (VAR_W+1)'(1)) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_VAR;
      ST_VAR:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      pn_r <= PN_RESET;
      mn_r <= MN_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        var_r[i] <= VAR_RESET;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_PROCESS_NOISE: pn_r <= cfg_wdata;
          REG_MEASURE_NOISE: mn_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_VAR) begin
        var_r[ch_r] <= nv_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          ch_r <= IDX_W'(in_channel);
          pred_r <= in_predicted_angle;
          meas_r <= in_measured_angle;
          angle_r <= in_predicted_angle;
          bad_r <= ({{(CMP_W-CH_IN_W){1'b0}}, in_channel} >= CMP_W'(NUM_CHANNELS));
        end
      end
      ST_PRIOR: begin
        p_r <= prior_sat;
        den_r <= {1'b0, prior_sat} + {1'b0, mn_r};
        cnt_r <= '0;
        quo_r <= '0;
        rem_r <= '0;
      end
      ST_DIV: begin
        rem_r <= div_rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(VAR_W)) begin
          v_r <= (den_r == '0) ? '0 : quo_nxt;
          res_r <= '0;
          bit_r <= (VAR_W+1)'(1) << VAR_W;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          v_r <= v_r - sq_sum[VAR_W:0];
        end
        res_r <= sq_res_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r == (VAR_W+1)'(1)) begin
          gain_r <= (sq_res_nxt >= (VAR_W+2)'(GAIN_ONE)) ? GAIN_ONE : sq_res_nxt[GAIN_BITS:0];
        end
      end
      ST_MUL1: begin
        prod_r <= mul_p;
      end
      ST_MUL2: begin
        if (acc_sh > ACC_W'(signed'(32'sh7FFF_FFFF))) begin
          angle_r <= 32'sh7FFF_FFFF;
        end else if (acc_sh < -(ACC_W'(64'sh8000_0000))) begin
          angle_r <= 32'sh8000_0000;
        end else begin
          angle_r <= acc_sh[ANGLE_W-1:0];
        end
        prod_r <= mul_p;
      end
      ST_OUT: begin
        if (out_free) begin
          out_angle_r <= angle_r;
          out_bad_r <= bad_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: test/tb_scalar_kalman_angle_fusion_unit.sv
// Testbench for scalar_kalman_angle_fusion_unit: drives angle requests, predicts each fused
// angle and channel variance update in-line, and checks every result over several noise settings.
// Depends on skaf_pkg and the scalar_kalman_angle_fusion_unit RTL.
module tb_scalar_kalman_angle_fusion_unit;
  import skaf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH = DEF_NUM_CHANNELS;
  localparam int N_PHASES = 7;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int STUCK_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [CH_IN_W-1:0]        channel;
    logic signed [ANGLE_W-1:0] pred;
    logic signed [ANGLE_W-1:0] meas;
  } angle_req_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic                      bad;
  } fused_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CH_IN_W-1:0] in_channel = '0;
  logic signed [ANGLE_W-1:0] in_predicted_angle = '0;
  logic signed [ANGLE_W-1:0] in_measured_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] out_filtered_angle;
  logic out_bad_channel;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAR_W-1:0] cfg_wdata = '0;

  logic [VAR_W-1:0] chan_var [NUM_CH];
  logic [VAR_W-1:0] proc_noise_m;
  logic [VAR_W-1:0] meas_noise_m;

  angle_req_t req_backlog[$];
  angle_req_t cur_req;
  fused_t fused_due[$];
  int reqs_queued = 0;
  int reqs_taken = 0;
  int fused_seen = 0;
  int mismatches = 0;
  int in_gap = 0;
  int out_wait = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  scalar_kalman_angle_fusion_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_predicted_angle(in_predicted_angle),
    .in_measured_angle (in_measured_angle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_filtered_angle(out_filtered_angle),
    .out_bad_channel   (out_bad_channel),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [16:0] gain_root(logic [63:0] v);
    logic [16:0] r;
    logic [16:0] t;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (17'd1 << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic fused_t kalman_fuse(angle_req_t rq);
    fused_t r;
    logic [VAR_W:0] prior_w;
    logic [VAR_W-1:0] prior;
    logic [VAR_W:0] den;
    logic [63:0] ratio;
    logic [16:0] gain;
    logic [63:0] nv;
    longint p_s;
    longint m_s;
    longint accl;
    longint res;
    if (rq.channel >= NUM_CH) begin
      r.angle = rq.pred;
      r.bad = 1'b1;
      return r;
    end
    prior_w = {1'b0, chan_var[rq.channel]} + {1'b0, proc_noise_m};
    prior = prior_w[VAR_W] ? '1 : prior_w[VAR_W-1:0];
    den = {1'b0, prior} + {1'b0, meas_noise_m};
    ratio = (den == '0) ? 64'd0 : {prior, 32'd0} / 64'(den);
    gain = gain_root(ratio);
    if (gain > 17'd65536) gain = 17'd65536;
    p_s = rq.pred;
    m_s = rq.meas;
    accl = p_s * 64'sd65536 + (m_s - p_s) * longint'(gain) + 64'sd32768;
    res = accl >>> GAIN_BITS;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    else if (res < -64'sd2147483648) res = -64'sd2147483648;
    nv = ((64'd65536 - 64'(gain)) * 64'(prior) + 64'd32768) >> GAIN_BITS;
    if (nv > 64'hFFFF_FFFF) nv = 64'hFFFF_FFFF;
    chan_var[rq.channel] = nv[VAR_W-1:0];
    r.angle = res[ANGLE_W-1:0];
    r.bad = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom();
      default: return $urandom_range(0, 47185920) - 32'd23592960;
    endcase
  endfunction

  task automatic queue_req(int ch, logic [31:0] pred, logic [31:0] meas);
    angle_req_t rq;
    rq.channel = CH_IN_W'(ch);
    rq.pred = pred;
    rq.meas = meas;
    req_backlog.push_back(rq);
    reqs_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAR_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_PROCESS_NOISE) proc_noise_m = val;
    else meas_noise_m = val;
  endtask

  always @(posedge clk) begin
    logic offer;
    offer = in_valid;
    if (in_valid && !in_stall) begin
      fused_due.push_back(kalman_fuse(cur_req));
      reqs_taken++;
      offer = 1'b0;
      in_gap = in_idle_on ? $urandom_range(0, 4) : 0;
    end
    if (!offer) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (req_backlog.size() > 0) begin
        cur_req = req_backlog.pop_front();
        in_channel <= cur_req.channel;
        in_predicted_angle <= cur_req.pred;
        in_measured_angle <= cur_req.meas;
        offer = 1'b1;
      end
    end
    in_valid <= offer;
  end

  always @(posedge clk) begin
    fused_t want;
    if (out_valid && !out_stall) begin
      fused_seen++;
      if (fused_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: angle=%0d bad=%0b", out_filtered_angle, out_bad_channel);
      end else begin
        want = fused_due.pop_front();
        if (out_filtered_angle !== want.angle || out_bad_channel !== want.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: angle exp=%0d got=%0d, bad exp=%0b got=%0b",
                     fused_seen, want.angle, out_filtered_angle, want.bad, out_bad_channel);
        end
      end
      out_wait = out_idle_on ? $urandom_range(0, 4) : 0;
    end
    if (!pressure_done && fused_seen == 150) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("tb_scalar_kalman_angle_fusion_unit: FAIL");
    $finish;
  end

  initial begin
    int ch;
    logic [31:0] pred;
    logic [31:0] meas;
    proc_noise_m = PN_RESET;
    meas_noise_m = MN_RESET;
    for (int c = 0; c < NUM_CH; c++) chan_var[c] = VAR_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      in_idle_on = (phase % 2) == 0;
      out_idle_on = ((phase / 2) % 2) == 0;
      if (phase > 0) begin
        case (phase)
          1: begin
            write_reg(REG_PROCESS_NOISE, '0);
            write_reg(REG_MEASURE_NOISE, 32'd1);
          end
          2: begin
            write_reg(REG_PROCESS_NOISE, '1);
            write_reg(REG_MEASURE_NOISE, '1);
          end
          3: begin
            write_reg(REG_PROCESS_NOISE, '0);
            write_reg(REG_MEASURE_NOISE, '0);
          end
          4: begin
            write_reg(REG_PROCESS_NOISE, $urandom());
            write_reg(REG_MEASURE_NOISE, $urandom_range(1, 32'hFFFF_FFFF));
          end
          5: begin
            write_reg(REG_PROCESS_NOISE, PN_RESET);
            write_reg(REG_MEASURE_NOISE, '1);
          end
          default: begin
            write_reg(REG_PROCESS_NOISE, $urandom_range(0, 65536));
            write_reg(REG_MEASURE_NOISE, $urandom_range(1, 262144));
          end
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end

      if (phase == 0) begin
        queue_req(0, 32'h0000_0000, 32'h0000_0000);
        queue_req(1, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(2, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_req(4, 32'h8000_0000, 32'h8000_0000);
        queue_req(0, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_req(1, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_req(5, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(6, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(7, 32'hFFFF_FFFF, 32'h1234_5678);
        queue_req(2, 32'(90 << 16), 32'(45 << 16));
        queue_req(3, -32'(30 << 16), 32'(30 << 16));
        for (int k = 0; k < 6; k++) queue_req(4, 32'(10 << 16), 32'(12 << 16));
      end else if (phase == 3) begin
        queue_req(2, 32'(5 << 16), -32'(5 << 16));
        queue_req(2, 32'(5 << 16), -32'(5 << 16));
        queue_req(2, 32'h8000_0000, 32'h7FFF_FFFF);
      end

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        ch = ($urandom_range(0, 7) == 0) ? $urandom_range(NUM_CH, 7) : $urandom_range(0, NUM_CH - 1);
        pred = rand_angle();
        meas = $urandom_range(0, 1) ? pred + ($urandom_range(0, 1310720) - 32'd655360)
                                    : rand_angle();
        queue_req(ch, pred, meas);
      end

      while (reqs_taken != reqs_queued || fused_due.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end

    repeat (70) @(posedge clk);
    if (mismatches == 0 && fused_due.size() == 0) begin
      $display("tb_scalar_kalman_angle_fusion_unit: PASS");
    end else begin
      $display("tb_scalar_kalman_angle_fusion_unit: FAIL");
    end
    $finish;
  end

endmodule
